// ===== hdl/tdk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_pkg
// Shared types and constants of the threshold debounce key event unit.
// ----------------------------------------------------------------------------
package tdk_pkg;

	localparam int NUM_CH      = 5;
	localparam int CH_BITS     = 3;
	localparam int SAMPLE_BITS = 10;
	localparam int DEB_BITS    = 16;
	localparam int KEY_BITS    = 8;
	localparam int NOW_BITS    = 32;
	localparam int IDX_BITS    = 3;
	localparam int CFG_BITS    = 16;

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] CFG_THR_CH0  = 3'd0;
	localparam logic [IDX_BITS-1:0] CFG_THR_CH1  = 3'd1;
	localparam logic [IDX_BITS-1:0] CFG_THR_CH2  = 3'd2;
	localparam logic [IDX_BITS-1:0] CFG_THR_CH3  = 3'd3;
	localparam logic [IDX_BITS-1:0] CFG_THR_CH4  = 3'd4;
	localparam logic [IDX_BITS-1:0] CFG_DEBOUNCE = 3'd5;
	localparam logic [IDX_BITS-1:0] CFG_KEY_BASE = 3'd6;

	// reset values of the configuration registers
	localparam logic [SAMPLE_BITS-1:0] THR_RESET [NUM_CH] = '{
		10'd830, 10'd870, 10'd810, 10'd840, 10'd710
	};
	localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [KEY_BITS-1:0] KEY_BASE_RESET = 8'd4;

	// levels: bent reads 0, released reads 1
	localparam logic LEVEL_RELEASED = 1'b1;

	// what the lanes found for one input beat
	typedef struct packed {
		logic [NUM_CH-1:0] fire;
		logic [NUM_CH-1:0] level;
	} tdk_lane_res_t;

endpackage

`default_nettype wire

// ===== hdl/tdk_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_if
// Valid/ready channels: sample beats in and key report beats out.
// ----------------------------------------------------------------------------
interface tdk_in_if;
	logic        valid;
	logic        ready;
	logic [9:0]  sample_ch0;
	logic [9:0]  sample_ch1;
	logic [9:0]  sample_ch2;
	logic [9:0]  sample_ch3;
	logic [9:0]  sample_ch4;
	logic [31:0] now_ms;

	modport source (
		output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, now_ms,
		input  ready
	);
	modport sink (
		input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, now_ms,
		output ready
	);
endinterface

interface tdk_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] channel;
	logic       pressed;
	logic [7:0] report_key;
	logic       last;

	modport source (
		output valid, channel, pressed, report_key, last,
		input  ready
	);
	modport sink (
		input  valid, channel, pressed, report_key, last,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/threshold_debounce_key_events_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_debounce_key_events_unit
// Five-channel threshold key debouncer emitting press and release reports.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  samples   in   five 10-bit samples and a millisecond timestamp
//  reports   out  channel, pressed, report key, last flag
//  cfg_*     in   register write: index 0..4 thresholds, 5 debounce, 6 key base
//
// Five lanes judge a sample beat in the cycle it is accepted; a beat causing
// n reports sends them one per cycle from the output register when not stalled,
// and the next beat is taken in the cycle the last report is loaded. Reset
// sets the registers, lanes, pending events and output valid flag, but not the
// report payload or stored levels. A stalled reports channel holds the output
// register; while reports of a beat wait to be loaded it holds off sample beats.
// ----------------------------------------------------------------------------
module threshold_debounce_key_events_unit #(
	parameter int TIME_BITS = 32
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [tdk_pkg::IDX_BITS-1:0]    cfg_index,
	input  wire [tdk_pkg::CFG_BITS-1:0]    cfg_data,
	tdk_in_if.sink                         samples,
	tdk_out_if.source                      reports
);
	import tdk_pkg::*;

	logic [SAMPLE_BITS-1:0] thr_q [NUM_CH];
	logic [DEB_BITS-1:0]    debounce_q;
	logic [KEY_BITS-1:0]    key_base_q;

	logic                   accept;
	logic                   take_ready;
	logic [TIME_BITS-1:0]   now;
	logic [SAMPLE_BITS-1:0] sample [NUM_CH];
	logic [NUM_CH-1:0]      fire;
	logic [NUM_CH-1:0]      level;
	tdk_lane_res_t          lanes;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				thr_q[i] <= THR_RESET[i];
			end
			debounce_q <= DEBOUNCE_RESET;
			key_base_q <= KEY_BASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THR_CH0:  thr_q[0]   <= cfg_data[SAMPLE_BITS-1:0];
				CFG_THR_CH1:  thr_q[1]   <= cfg_data[SAMPLE_BITS-1:0];
				CFG_THR_CH2:  thr_q[2]   <= cfg_data[SAMPLE_BITS-1:0];
				CFG_THR_CH3:  thr_q[3]   <= cfg_data[SAMPLE_BITS-1:0];
				CFG_THR_CH4:  thr_q[4]   <= cfg_data[SAMPLE_BITS-1:0];
				CFG_DEBOUNCE: debounce_q <= cfg_data[DEB_BITS-1:0];
				CFG_KEY_BASE: key_base_q <= cfg_data[KEY_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input beat handshake and payload
	assign samples.ready = take_ready;
	assign accept        = samples.valid && take_ready;
	assign now           = TIME_BITS'(samples.now_ms);
	assign sample[0]     = samples.sample_ch0;
	assign sample[1]     = samples.sample_ch1;
	assign sample[2]     = samples.sample_ch2;
	assign sample[3]     = samples.sample_ch3;
	assign sample[4]     = samples.sample_ch4;

	// one lane per channel
	for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
		tdk_lane #(
			.TIME_BITS (TIME_BITS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.accept    (accept),
			.sample    (sample[g]),
			.now       (now),
			.threshold (thr_q[g]),
			.debounce  (debounce_q),
			.fire      (fire[g]),
			.level     (level[g])
		);
	end

	assign lanes.fire  = fire;
	assign lanes.level = level;

	// report serializer
	tdk_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.lanes      (lanes),
		.key_base   (key_base_q),
		.take_ready (take_ready),
		.reports    (reports)
	);

endmodule

`default_nettype wire

// ===== hdl/tdk_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_lane
// One channel: threshold compare, change timer and stable level tracking.
// ----------------------------------------------------------------------------
module tdk_lane #(
	parameter int TIME_BITS = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              accept,
	input  wire [tdk_pkg::SAMPLE_BITS-1:0]   sample,
	input  wire [TIME_BITS-1:0]              now,
	input  wire [tdk_pkg::SAMPLE_BITS-1:0]   threshold,
	input  wire [tdk_pkg::DEB_BITS-1:0]      debounce,
	output logic                             fire,
	output logic                             level
);
	import tdk_pkg::*;

	logic                 raw_prev_q;
	logic                 stable_q;
	logic [TIME_BITS-1:0] change_time_q;
	logic                 raw;
	logic [TIME_BITS-1:0] elapsed;

	// raw level and elapsed time since the last raw change
	always_comb begin
		raw     = (sample > threshold) ? 1'b0 : 1'b1;
		elapsed = now - change_time_q;
		// a fresh change differs from the previous raw level and never reports
		fire    = (raw == raw_prev_q) && (elapsed > TIME_BITS'(debounce))
		          && (raw != stable_q);
		level   = raw;
	end

	// channel state, updated once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_prev_q    <= LEVEL_RELEASED;
			stable_q      <= LEVEL_RELEASED;
			change_time_q <= '0;
		end else if (accept) begin
			raw_prev_q <= raw;
			if (raw != raw_prev_q) begin
				change_time_q <= now;
			end
			if (fire) begin
				stable_q <= raw;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tdk_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdk_merge
// Collects the lane events of one beat and sends them out in channel order.
// ----------------------------------------------------------------------------
module tdk_merge (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            accept,
	input  wire tdk_pkg::tdk_lane_res_t    lanes,
	input  wire [tdk_pkg::KEY_BITS-1:0]    key_base,
	output logic                           take_ready,
	tdk_out_if.source                      reports
);
	import tdk_pkg::*;

	logic [NUM_CH-1:0]   mask_q;
	logic [NUM_CH-1:0]   level_q;
	logic                out_valid_q;
	logic [CH_BITS-1:0]  out_channel_q;
	logic                out_pressed_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic                out_last_q;

	logic [CH_BITS-1:0]  pick;
	logic [NUM_CH-1:0]   rest;
	logic                load;

	// lowest pending channel and what stays after it
	always_comb begin
		pick = '0;
		for (int i = NUM_CH - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick = CH_BITS'(i);
			end
		end
		rest       = mask_q & (mask_q - NUM_CH'(1));
		load       = (mask_q != '0) && (!out_valid_q || reports.ready);
		take_ready = (mask_q == '0) || ((rest == '0) && load);
	end

	// pending events of the current beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (accept) begin
			mask_q <= lanes.fire;
		end else if (load) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_q <= lanes.level;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (reports.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_channel_q <= pick;
			out_pressed_q <= ~level_q[pick];
			out_key_q     <= level_q[pick] ? '0 : key_base + KEY_BITS'(pick);
			out_last_q    <= (rest == '0);
		end
	end

	assign reports.valid      = out_valid_q;
	assign reports.channel    = out_channel_q;
	assign reports.pressed    = out_pressed_q;
	assign reports.report_key = out_key_q;
	assign reports.last       = out_last_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the threshold debounce key event unit. A class keeps
// its own copy of the per-channel debounce state and the registers, queues
// the key reports each sample beat should cause and checks report beats in
// order against that queue, under several register settings and paces.
// ----------------------------------------------------------------------------
module tb;
	import tdk_pkg::*;

	localparam logic [IDX_BITS-1:0] CFG_UNMAPPED = 3'd7;
	localparam int MAX_SHOWN    = 10;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_BEATS  = 25;

	typedef struct packed {
		logic [CH_BITS-1:0]  channel;
		logic                pressed;
		logic [KEY_BITS-1:0] report_key;
		logic                last;
	} key_report_t;

	typedef logic [SAMPLE_BITS-1:0] sample_vec_t [NUM_CH];
	typedef logic [CFG_BITS-1:0]    thr_cfg_t [NUM_CH];

	typedef enum {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

	// mirror of the debouncer and queue of the reports it owes
	class key_report_board;
		logic [SAMPLE_BITS-1:0] thr [NUM_CH];
		logic [DEB_BITS-1:0]    debounce;
		logic [KEY_BITS-1:0]    key_base;
		logic                   raw_prev [NUM_CH];
		logic                   stable [NUM_CH];
		logic [NOW_BITS-1:0]    changed_at [NUM_CH];
		key_report_t            pending_reports [$];
		int                     errors;

		function new();
			for (int i = 0; i < NUM_CH; i++) begin
				thr[i]        = THR_RESET[i];
				raw_prev[i]   = LEVEL_RELEASED;
				stable[i]     = LEVEL_RELEASED;
				changed_at[i] = '0;
			end
			debounce = DEBOUNCE_RESET;
			key_base = KEY_BASE_RESET;
			errors   = 0;
		endfunction

		function void fail(string msg);
			errors++;
			if (errors <= MAX_SHOWN)
				$display("%0t: %s", $realtime, msg);
		endfunction

		// register write, unmapped indexes have no effect
		function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
			case (idx)
				CFG_THR_CH0, CFG_THR_CH1, CFG_THR_CH2, CFG_THR_CH3, CFG_THR_CH4:
					thr[idx] = data[SAMPLE_BITS-1:0];
				CFG_DEBOUNCE: debounce = data[DEB_BITS-1:0];
				CFG_KEY_BASE: key_base = data[KEY_BITS-1:0];
				default: ;
			endcase
		endfunction

		// one accepted sample beat: update lanes, queue the reports in channel order
		function void note_samples(sample_vec_t smp, logic [NOW_BITS-1:0] now);
			logic                raw;
			logic [NOW_BITS-1:0] elapsed;
			key_report_t         rep;
			int                  count;
			count = 0;
			for (int i = 0; i < NUM_CH; i++) begin
				raw = (smp[i] > thr[i]) ? 1'b0 : 1'b1;
				if (raw != raw_prev[i])
					changed_at[i] = now;
				elapsed = now - changed_at[i];
				if (elapsed > NOW_BITS'(debounce) && raw != stable[i]) begin
					stable[i]      = raw;
					rep.channel    = CH_BITS'(i);
					rep.pressed    = ~raw;
					rep.report_key = raw ? '0 : KEY_BITS'(key_base + KEY_BITS'(i));
					rep.last       = 1'b0;
					pending_reports.push_back(rep);
					count++;
				end
				raw_prev[i] = raw;
			end
			if (count > 0)
				pending_reports[pending_reports.size() - 1].last = 1'b1;
		endfunction

		// one accepted report beat against the oldest expectation
		function void check_report(key_report_t got);
			key_report_t want;
			if (pending_reports.size() == 0) begin
				fail($sformatf("unexpected report ch=%0d pressed=%0b key=%0d last=%0b",
					got.channel, got.pressed, got.report_key, got.last));
				return;
			end
			want = pending_reports.pop_front();
			if (got.channel !== want.channel || got.pressed !== want.pressed ||
					got.report_key !== want.report_key || got.last !== want.last)
				fail($sformatf({"report mismatch: want ch=%0d pressed=%0b key=%0d last=%0b,",
					" got ch=%0d pressed=%0b key=%0d last=%0b"},
					want.channel, want.pressed, want.report_key, want.last,
					got.channel, got.pressed, got.report_key, got.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic                cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	tdk_in_if  samples_if ();
	tdk_out_if reports_if ();

	key_report_board board;
	sample_vec_t     seen_smp;
	logic [31:0]     clock_ms;
	logic            want_bent [NUM_CH];
	int              send_idle_pct;
	int              recv_idle_pct;

	threshold_debounce_key_events_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_if),
		.reports   (reports_if)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		reports_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// beat monitor: reports first, then the sample beat taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (reports_if.valid && reports_if.ready)
				board.check_report(key_report_t'({reports_if.channel, reports_if.pressed,
					reports_if.report_key, reports_if.last}));
			if (samples_if.valid && samples_if.ready) begin
				seen_smp = '{samples_if.sample_ch0, samples_if.sample_ch1,
					samples_if.sample_ch2, samples_if.sample_ch3, samples_if.sample_ch4};
				board.note_samples(seen_smp, samples_if.now_ms);
			end
		end
	end

	task automatic set_pace(pace_t pace);
		case (pace)
			PACE_SLOW_SINK: begin
				send_idle_pct = 24;
				recv_idle_pct = 86;
			end
			PACE_SLOW_SOURCE: begin
				send_idle_pct = 86;
				recv_idle_pct = 24;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// one sample beat, returns at the falling edge after acceptance
	task automatic send_beat(sample_vec_t smp, logic [31:0] now);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			samples_if.valid = 1'b0;
			@(negedge clk);
		end
		samples_if.valid      = 1'b1;
		samples_if.sample_ch0 = smp[0];
		samples_if.sample_ch1 = smp[1];
		samples_if.sample_ch2 = smp[2];
		samples_if.sample_ch3 = smp[3];
		samples_if.sample_ch4 = smp[4];
		samples_if.now_ms     = now;
		do
			@(posedge clk);
		while (!(samples_if.valid && samples_if.ready));
		@(negedge clk);
	endtask

	// hold off input until every owed report is out and the unit has settled
	task automatic wait_reports_done();
		samples_if.valid = 1'b0;
		while (board.pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		board.write_reg(idx, data);
	endtask

	// full register set plus a write to the unmapped index
	task automatic program_regs(thr_cfg_t thr_data, logic [CFG_BITS-1:0] deb,
			logic [CFG_BITS-1:0] base);
		for (int i = 0; i < NUM_CH; i++)
			write_reg(IDX_BITS'(CFG_THR_CH0 + i), thr_data[i]);
		write_reg(CFG_DEBOUNCE, deb);
		write_reg(CFG_KEY_BASE, base);
		write_reg(CFG_UNMAPPED, CFG_BITS'($urandom()));
	endtask

	// directed beats under reset settings
	task automatic run_directed();
		sample_vec_t smp;
		// released everywhere, nothing owed
		smp = '{default: 10'd0};
		send_beat(smp, 32'd0);
		send_beat(smp, 32'd100);
		// full scale: fresh change, hold of exactly the wait, then one past it
		smp = '{default: 10'd1023};
		send_beat(smp, 32'd1000);
		send_beat(smp, 32'd1050);
		send_beat(smp, 32'd1051);
		// sample equal to threshold reads released
		foreach (smp[i]) smp[i] = board.thr[i];
		send_beat(smp, 32'd2000);
		send_beat(smp, 32'd2051);
		// one above threshold reads bent
		foreach (smp[i]) smp[i] = board.thr[i] + 10'd1;
		send_beat(smp, 32'd3000);
		send_beat(smp, 32'd3051);
		// partial release, last flag on the highest reporting channel
		smp = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0};
		send_beat(smp, 32'd4000);
		send_beat(smp, 32'd4051);
		smp = '{10'd0, 10'd0, 10'd0, 10'd1023, 10'd0};
		send_beat(smp, 32'd4100);
		send_beat(smp, 32'd4160);
		// press across the time wrap
		smp = '{default: 10'd1023};
		send_beat(smp, 32'hFFFF_FFFF);
		send_beat(smp, 32'h0000_0040);
		smp = '{default: 10'd0};
		send_beat(smp, 32'h0000_0050);
		send_beat(smp, 32'h0000_0083);
	endtask

	// random beats: mostly held levels with advancing time, some noise
	task automatic run_random(int n);
		sample_vec_t smp;
		int          step;
		int          deb;
		int          t;
		deb      = board.debounce;
		clock_ms = 32'h0 - 32'($urandom_range(0, 4 * deb + 200));
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				// noise: arbitrary readings, sometimes a jump in time
				foreach (smp[i]) smp[i] = SAMPLE_BITS'($urandom_range(0, 1023));
				if ($urandom_range(0, 1) != 0)
					clock_ms = $urandom();
			end else begin
				case ($urandom_range(0, 3))
					0: step = 0;
					1: step = $urandom_range(0, deb);
					2: step = deb + 1 + $urandom_range(0, 40);
					default: step = $urandom_range(0, 2 * deb + 10);
				endcase
				clock_ms += step;
				for (int i = 0; i < NUM_CH; i++) begin
					if ($urandom_range(0, 3) == 0)
						want_bent[i] = ~want_bent[i];
					t = board.thr[i];
					if (want_bent[i] && t < 1023)
						smp[i] = SAMPLE_BITS'($urandom_range(1023, t + 1));
					else
						smp[i] = SAMPLE_BITS'($urandom_range(t, 0));
				end
			end
			if ($urandom_range(0, 24) == 0)
				wait_reports_done();
			send_beat(smp, clock_ms);
		end
	endtask

	// run limit
	initial begin
		#3_000_000;
		$display("[threshold_debounce_key_events_unit] ERROR");
		$finish;
	end

	// main sequence
	initial begin
		thr_cfg_t thr_data;
		board = new();
		foreach (want_bent[i]) want_bent[i] = 1'b0;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_data              = '0;
		samples_if.valid      = 1'b0;
		samples_if.sample_ch0 = '0;
		samples_if.sample_ch1 = '0;
		samples_if.sample_ch2 = '0;
		samples_if.sample_ch3 = '0;
		samples_if.sample_ch4 = '0;
		samples_if.now_ms     = '0;
		reports_if.ready      = 1'b0;
		clock_ms              = '0;
		set_pace(PACE_SLOW_SINK);
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		run_directed();
		wait_reports_done();

		// random registers, upper data bits set freely
		foreach (thr_data[i]) thr_data[i] = CFG_BITS'($urandom());
		program_regs(thr_data, CFG_BITS'($urandom_range(0, 300)), CFG_BITS'($urandom()));
		run_random(PHASE_BEATS);
		wait_reports_done();

		// low extremes: any nonzero sample is bent, no wait, key code wraps
		set_pace(PACE_SLOW_SOURCE);
		thr_data = '{default: 16'hFC00};
		program_regs(thr_data, 16'd0, 16'h00FF);
		run_random(PHASE_BEATS);
		wait_reports_done();

		// high extremes: some channels never bent, longest wait
		thr_data = '{16'd1023, 16'd1022, 16'd0, 16'd512, 16'hFFFF};
		program_regs(thr_data, 16'hFFFF, 16'd251);
		run_random(PHASE_BEATS);
		wait_reports_done();

		// random registers at full rate
		set_pace(PACE_FULL);
		foreach (thr_data[i]) thr_data[i] = CFG_BITS'($urandom_range(0, 1023));
		program_regs(thr_data, CFG_BITS'($urandom_range(0, 120)),
			CFG_BITS'($urandom_range(0, 251)));
		run_random(PHASE_BEATS);
		wait_reports_done();

		if (board.errors == 0)
			$display("[threshold_debounce_key_events_unit] OK");
		else
			$display("[threshold_debounce_key_events_unit] ERROR");
		$finish;
	end

endmodule
